[sv/pan_tilt_scan_point_tagger_unit_defines.svh]
// assertion macros for the pan/tilt scan point tagger
`ifndef PAN_TILT_SCAN_POINT_TAGGER_UNIT_DEFINES_SVH
`define PAN_TILT_SCAN_POINT_TAGGER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PTTAG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pttag assertion failed");
`define PTTAG_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("pttag forbidden condition seen");
`else
`define PTTAG_ASSERT(lbl, clk, rstn, prop)
`define PTTAG_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[sv/pttag_pkg.sv]
// shared types and constants of the pan/tilt scan point tagger
`default_nettype none
package pttag_pkg;

    localparam int PULSE_W     = 12;
    localparam int STEP_W      = 13;
    localparam int WORD_W      = 16;
    localparam int COUNT_W     = 8;
    localparam int POS_W       = 4;
    localparam int FRAME_STORE = 6;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 56;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [7:0] FRAME_HDR = 8'h59;

    localparam logic       MODE_TICK = 1'b0;
    localparam logic       MODE_BYTE = 1'b1;

    localparam logic [1:0] KIND_PAN   = 2'd0;
    localparam logic [1:0] KIND_TILT  = 2'd1;
    localparam logic [1:0] KIND_POINT = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_TILT_FIRST   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TILT_LAST    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TILT_INC     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAN_LOW      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAN_HIGH     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAN_COUNT    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_STRENGTH_THR = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIST_LIMIT   = 3'd7;

    localparam logic [PULSE_W-1:0] RST_TILT_FIRST    = 12'd2000;
    localparam logic [PULSE_W-1:0] RST_TILT_LAST     = 12'd2500;
    localparam logic [PULSE_W-1:0] RST_TILT_INC      = 12'd50;
    localparam logic [PULSE_W-1:0] RST_PAN_LOW       = 12'd500;
    localparam logic [PULSE_W-1:0] RST_PAN_HIGH      = 12'd2000;
    localparam logic [COUNT_W-1:0] RST_PAN_COUNT     = 8'd100;
    localparam logic [WORD_W-1:0]  RST_STRENGTH_THR  = 16'd50;
    localparam logic [WORD_W-1:0]  RST_DIST_LIMIT    = 16'd6000;
    localparam logic [PULSE_W-1:0] RST_REPORTED_PAN  = 12'd500;
    localparam logic [PULSE_W-1:0] RST_REPORTED_TILT = 12'd2000;

    typedef enum logic [1:0] {
        CTL_IDLE = 2'b01,
        CTL_DIV  = 2'b10
    } ctl_state_t;

    typedef enum logic [3:0] {
        PH_TILT   = 4'b0001,
        PH_SETTLE = 4'b0010,
        PH_PAN    = 4'b0100,
        PH_DONE   = 4'b1000
    } sweep_phase_t;

    typedef struct packed {
        logic                start;
        logic [PULSE_W-1:0]  dividend;
        logic [COUNT_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [PULSE_W-1:0]  quotient;
    } div_resp_t;

    typedef struct packed {
        logic                point_ok;
        logic [WORD_W-1:0]   distance;
    } frame_result_t;

endpackage
`default_nettype wire

[sv/pttag_div.sv]
// bit-serial restoring divider for the per-row pan step
`default_nettype none
module pttag_div (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire pttag_pkg::div_req_t req,
    output pttag_pkg::div_resp_t     resp
);

    localparam int ITER   = pttag_pkg::PULSE_W;
    localparam int CNT_W  = $clog2(ITER);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [pttag_pkg::COUNT_W-1:0]    rem_reg, rem_next;
    logic [pttag_pkg::COUNT_W-1:0]    divisor_reg, divisor_next;
    logic [pttag_pkg::PULSE_W-1:0]    work_reg, work_next;
    logic [pttag_pkg::COUNT_W:0]      rem_shift;
    logic                             fits;

    // one quotient bit per cycle, msb first
    assign rem_shift = {rem_reg, work_reg[pttag_pkg::PULSE_W-1]};
    assign fits      = rem_shift >= {1'b0, divisor_reg};

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        work_next    = work_reg;
        if (req.start) begin
            busy_next    = 1'b1;
            count_next   = CNT_W'(ITER - 1);
            rem_next     = '0;
            divisor_next = req.divisor;
            work_next    = req.dividend;
        end else if (busy_reg) begin
            rem_next  = fits ? pttag_pkg::COUNT_W'(rem_shift - {1'b0, divisor_reg})
                             : rem_shift[pttag_pkg::COUNT_W-1:0];
            work_next = {work_reg[pttag_pkg::PULSE_W-2:0], fits};
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        count_reg   <= count_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        work_reg    <= work_next;
    end

    assign resp.done     = done_reg;
    assign resp.quotient = work_reg;

endmodule
`default_nettype wire

[sv/pttag_frame.sv]
// lidar frame assembler and point filter
`default_nettype none
module pttag_frame #(
    parameter int FRAME_LENGTH = 9
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          byte_en,
    input  wire logic [7:0]                    rx_byte,
    input  wire logic [pttag_pkg::WORD_W-1:0]  strength_threshold,
    input  wire logic [pttag_pkg::WORD_W-1:0]  distance_limit,
    output pttag_pkg::frame_result_t           result
);

    localparam logic [pttag_pkg::POS_W-1:0] LAST_POS =
        pttag_pkg::POS_W'(FRAME_LENGTH - 1);

    logic [pttag_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]                  bytes_reg [pttag_pkg::FRAME_STORE];
    logic [7:0]                  view      [pttag_pkg::FRAME_STORE];
    logic [pttag_pkg::WORD_W-1:0] range_val, strength;
    logic                        frame_end;

    // the byte arriving now is seen in place of its stored copy
    always_comb begin
        for (int i = 0; i < pttag_pkg::FRAME_STORE; i++) begin
            view[i] = (pos_reg == pttag_pkg::POS_W'(i)) ? rx_byte : bytes_reg[i];
        end
    end

    assign range_val = {view[3], view[2]};
    assign strength  = {view[5], view[4]};
    assign frame_end = byte_en && (pos_reg == LAST_POS);

    assign result.point_ok = frame_end && (view[0] == pttag_pkg::FRAME_HDR)
                          && (view[1] == pttag_pkg::FRAME_HDR)
                          && (strength > strength_threshold)
                          && (range_val < distance_limit);
    assign result.distance = range_val;

    always_comb begin
        pos_next = pos_reg;
        if (byte_en) begin
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + pttag_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // checksum bytes past the store are counted only
    always_ff @(posedge aclk) begin
        for (int i = 0; i < pttag_pkg::FRAME_STORE; i++) begin
            if (byte_en && pos_reg == pttag_pkg::POS_W'(i)) begin
                bytes_reg[i] <= rx_byte;
            end
        end
    end

endmodule
`default_nettype wire

[sv/pan_tilt_scan_point_tagger_unit.sv]
// top level: serpentine pan/tilt sweep sequencer with lidar point tagging
// a result is in the output register in the cycle after its item is taken
// throughput: one item per cycle unless the output stalls; the settle-ending tick
//   with a nonzero pan count holds the input until the divider has formed the step
// reset (aresetn low, synchronous): registers take their documented defaults,
//   the sweep waits to issue its first tilt command and frame position is zero
`default_nettype none
`include "pan_tilt_scan_point_tagger_unit_defines.svh"
module pan_tilt_scan_point_tagger_unit #(
    parameter int SETTLE_TICKS = 9,
    parameter int FRAME_LENGTH = 9
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input transaction
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [pttag_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] rx_byte
    input  wire logic                                s_tuser,   // [0] mode
    // result transaction
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [11:0] servo_pulse, [23:12] point_pan, [35:24] point_tilt,
    // [51:36] point_distance, [55:52] zero
    output logic [pttag_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic [1:0]                               m_tuser,   // [1:0] kind
    // configuration writes
    input  wire logic                                cfg_we,
    input  wire logic [pttag_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [pttag_pkg::WORD_W-1:0]        cfg_data
);

    localparam int PW = pttag_pkg::PULSE_W;
    localparam int CW = pttag_pkg::COUNT_W;
    localparam logic [CW-1:0] SETTLE_LAST = CW'(SETTLE_TICKS);

    // configuration registers; the first tilt goes straight into the restart
    logic [PW-1:0]                tilt_last_reg, tilt_inc_reg;
    logic [PW-1:0]                pan_low_reg, pan_high_reg;
    logic [CW-1:0]                pan_count_reg;
    logic [pttag_pkg::WORD_W-1:0] strength_thr_reg, dist_limit_reg;

    // sweep state
    pttag_pkg::ctl_state_t   ctl_reg, ctl_next;
    pttag_pkg::sweep_phase_t phase_reg, phase_next;
    logic [PW-1:0]                  reported_pan_reg, reported_pan_next;
    logic [PW-1:0]                  reported_tilt_reg, reported_tilt_next;
    logic [PW-1:0]                  tilt_target_reg, tilt_target_next;
    logic [PW-1:0]                  pan_command_reg, pan_command_next;
    logic [pttag_pkg::STEP_W-1:0]   signed_step_reg, signed_step_next;
    logic [CW-1:0]                  step_index_reg, step_index_next;
    logic [CW-1:0]                  settle_reg, settle_next;
    logic                           forward_reg, forward_next;

    // output register
    logic                           m_valid_reg, m_valid_next;
    logic [1:0]                     m_kind_reg, m_kind_next;
    logic [pttag_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                           s_accept, tick_en, byte_en, restart;
    logic                           res_valid;
    logic [1:0]                     res_kind;
    logic [PW-1:0]                  res_pulse;
    logic                           div_start;

    logic [pttag_pkg::STEP_W-1:0]   pan_diff;
    logic [pttag_pkg::STEP_W-1:0]   quot_ext;
    logic                           step_neg;
    logic [PW:0]                    tilt_sum;
    logic [CW-1:0]                  settle_inc, index_inc;

    // assertion helpers
    logic                           sweep_done, in_div, point_out;

    pttag_pkg::div_req_t      div_req;
    pttag_pkg::div_resp_t     div_resp;
    pttag_pkg::frame_result_t frame_res;

    // one result slot; the next item may enter as the waiting one leaves
    assign s_tready = (ctl_reg == pttag_pkg::CTL_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign tick_en  = s_accept && (s_tuser == pttag_pkg::MODE_TICK);
    assign byte_en  = s_accept && (s_tuser == pttag_pkg::MODE_BYTE);
    assign restart  = cfg_we && (cfg_addr == pttag_pkg::CFG_TILT_FIRST);

    // row step: |pan_high - pan_low| / pan count, sign applied after
    assign pan_diff   = {1'b0, pan_high_reg} - {1'b0, pan_low_reg};
    assign step_neg   = pan_diff[pttag_pkg::STEP_W-1] ^ ~forward_reg;
    assign quot_ext   = {1'b0, div_resp.quotient};
    assign tilt_sum   = {1'b0, tilt_target_reg} + {1'b0, tilt_inc_reg};
    assign settle_inc = settle_reg + CW'(1);
    assign index_inc  = step_index_reg + CW'(1);

    assign div_req.start    = div_start;
    assign div_req.divisor  = pan_count_reg;
    assign div_req.dividend = pan_diff[pttag_pkg::STEP_W-1] ? PW'(-pan_diff) : pan_diff[PW-1:0];

    pttag_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    pttag_frame #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_frame (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .byte_en            (byte_en),
        .rx_byte            (s_tdata[7:0]),
        .strength_threshold (strength_thr_reg),
        .distance_limit     (dist_limit_reg),
        .result             (frame_res)
    );

    // sweep sequencer
    always_comb begin
        ctl_next           = ctl_reg;
        phase_next         = phase_reg;
        reported_pan_next  = reported_pan_reg;
        reported_tilt_next = reported_tilt_reg;
        tilt_target_next   = tilt_target_reg;
        pan_command_next   = pan_command_reg;
        signed_step_next   = signed_step_reg;
        step_index_next    = step_index_reg;
        settle_next        = settle_reg;
        forward_next       = forward_reg;
        div_start          = 1'b0;
        res_valid          = 1'b0;
        res_kind           = pttag_pkg::KIND_PAN;
        res_pulse          = '0;

        case (ctl_reg)
            pttag_pkg::CTL_IDLE: begin
                if (tick_en) begin
                    case (phase_reg)
                        pttag_pkg::PH_TILT: begin
                            if (tilt_target_reg > tilt_last_reg) begin
                                phase_next = pttag_pkg::PH_DONE;
                            end else begin
                                res_valid   = 1'b1;
                                res_kind    = pttag_pkg::KIND_TILT;
                                res_pulse   = tilt_target_reg;
                                settle_next = '0;
                                phase_next  = pttag_pkg::PH_SETTLE;
                            end
                        end
                        pttag_pkg::PH_SETTLE: begin
                            settle_next = settle_inc;
                            if (settle_inc >= SETTLE_LAST) begin
                                reported_tilt_next = tilt_target_reg;
                                pan_command_next   = forward_reg ? pan_low_reg : pan_high_reg;
                                step_index_next    = '0;
                                phase_next         = pttag_pkg::PH_PAN;
                                if (pan_count_reg == '0) begin
                                    // single pan position, no step
                                    signed_step_next = '0;
                                end else begin
                                    div_start = 1'b1;
                                    ctl_next  = pttag_pkg::CTL_DIV;
                                end
                            end
                        end
                        pttag_pkg::PH_PAN: begin
                            res_valid         = 1'b1;
                            res_kind          = pttag_pkg::KIND_PAN;
                            res_pulse         = pan_command_reg;
                            reported_pan_next = pan_command_reg;
                            pan_command_next  = pan_command_reg + signed_step_reg[PW-1:0];
                            step_index_next   = index_inc;
                            if (index_inc > pan_count_reg || index_inc == '0) begin
                                forward_next = ~forward_reg;
                                if (tilt_sum > {1'b0, tilt_last_reg}) begin
                                    phase_next = pttag_pkg::PH_DONE;
                                end else begin
                                    tilt_target_next = tilt_sum[PW-1:0];
                                    phase_next       = pttag_pkg::PH_TILT;
                                end
                            end
                        end
                        pttag_pkg::PH_DONE: begin
                            phase_next = pttag_pkg::PH_DONE;
                        end
                        default: begin
                            phase_next = pttag_pkg::PH_DONE;
                        end
                    endcase
                end else if (byte_en && frame_res.point_ok) begin
                    res_valid = 1'b1;
                    res_kind  = pttag_pkg::KIND_POINT;
                end
            end
            pttag_pkg::CTL_DIV: begin
                if (div_resp.done) begin
                    signed_step_next = step_neg ? pttag_pkg::STEP_W'(-quot_ext) : quot_ext;
                    ctl_next         = pttag_pkg::CTL_IDLE;
                end
            end
            default: begin
                ctl_next = pttag_pkg::CTL_IDLE;
            end
        endcase

        // a new first tilt restarts the sweep on a forward row
        if (restart) begin
            tilt_target_next = cfg_data[PW-1:0];
            pan_command_next = '0;
            signed_step_next = '0;
            step_index_next  = '0;
            forward_next     = 1'b1;
            phase_next       = pttag_pkg::PH_TILT;
            settle_next      = '0;
        end
    end

    // output register load
    always_comb begin
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_data_next  = m_data_reg;
        if (s_accept && res_valid) begin
            m_valid_next = 1'b1;
            m_kind_next  = res_kind;
            if (res_kind == pttag_pkg::KIND_POINT) begin
                m_data_next = {4'd0, frame_res.distance, reported_tilt_reg,
                               reported_pan_reg, 12'd0};
            end else begin
                m_data_next = {44'd0, res_pulse};
            end
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg           <= pttag_pkg::CTL_IDLE;
            phase_reg         <= pttag_pkg::PH_TILT;
            reported_pan_reg  <= pttag_pkg::RST_REPORTED_PAN;
            reported_tilt_reg <= pttag_pkg::RST_REPORTED_TILT;
            tilt_target_reg   <= pttag_pkg::RST_TILT_FIRST;
            pan_command_reg   <= '0;
            signed_step_reg   <= '0;
            step_index_reg    <= '0;
            settle_reg        <= '0;
            forward_reg       <= 1'b1;
            m_valid_reg       <= 1'b0;
        end else begin
            ctl_reg           <= ctl_next;
            phase_reg         <= phase_next;
            reported_pan_reg  <= reported_pan_next;
            reported_tilt_reg <= reported_tilt_next;
            tilt_target_reg   <= tilt_target_next;
            pan_command_reg   <= pan_command_next;
            signed_step_reg   <= signed_step_next;
            step_index_reg    <= step_index_next;
            settle_reg        <= settle_next;
            forward_reg       <= forward_next;
            m_valid_reg       <= m_valid_next;
        end
        m_kind_reg <= m_kind_next;
        m_data_reg <= m_data_next;
    end

    // configuration register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tilt_last_reg    <= pttag_pkg::RST_TILT_LAST;
            tilt_inc_reg     <= pttag_pkg::RST_TILT_INC;
            pan_low_reg      <= pttag_pkg::RST_PAN_LOW;
            pan_high_reg     <= pttag_pkg::RST_PAN_HIGH;
            pan_count_reg    <= pttag_pkg::RST_PAN_COUNT;
            strength_thr_reg <= pttag_pkg::RST_STRENGTH_THR;
            dist_limit_reg   <= pttag_pkg::RST_DIST_LIMIT;
        end else if (cfg_we) begin
            case (cfg_addr)
                pttag_pkg::CFG_TILT_FIRST: begin
                    // loaded into the tilt target by the sweep restart
                end
                pttag_pkg::CFG_TILT_LAST:    tilt_last_reg    <= cfg_data[PW-1:0];
                pttag_pkg::CFG_TILT_INC:     tilt_inc_reg     <= cfg_data[PW-1:0];
                pttag_pkg::CFG_PAN_LOW:      pan_low_reg      <= cfg_data[PW-1:0];
                pttag_pkg::CFG_PAN_HIGH:     pan_high_reg     <= cfg_data[PW-1:0];
                pttag_pkg::CFG_PAN_COUNT:    pan_count_reg    <= cfg_data[CW-1:0];
                pttag_pkg::CFG_STRENGTH_THR: strength_thr_reg <= cfg_data;
                pttag_pkg::CFG_DIST_LIMIT:   dist_limit_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = m_data_reg;

    assign sweep_done = (phase_reg == pttag_pkg::PH_DONE);
    assign in_div     = (ctl_reg == pttag_pkg::CTL_DIV);
    assign point_out  = m_valid_reg && (m_kind_reg == pttag_pkg::KIND_POINT);

    // no item enters while the divider forms the step
    `PTTAG_NEVER(a_no_accept_in_div, aclk, aresetn, in_div && s_tready)
    // a finished sweep stays finished until the first tilt is rewritten
    `PTTAG_ASSERT(a_done_holds, aclk, aresetn, sweep_done && !restart |=> sweep_done)
    // points carry no servo pulse
    `PTTAG_ASSERT(a_point_fields, aclk, aresetn, point_out |-> m_data_reg[11:0] == 12'd0)
    // the divider only runs while the sequencer waits on it
    `PTTAG_NEVER(a_div_done_idle, aclk, aresetn, div_resp.done && !in_div)

endmodule
`default_nettype wire
